// ----- design/gsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared types and constants of the gamepad stick conditioner.
// ----------------------------------------------------------------------------
package gsc_pkg;

   localparam int PAD_SLOTS    = 4;
   localparam int NUM_BUTTONS  = 14;
   localparam int CHARGE_WIDTH = 24;
   localparam int PAD_BITS     = 2;
   localparam int FULL_SCALE   = 32767;

   localparam logic [1:0] BTN_NONE     = 2'd0;
   localparam logic [1:0] BTN_DOWN     = 2'd1;
   localparam logic [1:0] BTN_HELD     = 2'd2;
   localparam logic [1:0] BTN_RELEASED = 2'd3;

   localparam logic [1:0] CHG_IDLE     = 2'd0;
   localparam logic [1:0] CHG_CHARGING = 2'd1;
   localparam logic [1:0] CHG_RELEASED = 2'd2;

   localparam logic [1:0] REG_LEFT_DZ   = 2'd0;
   localparam logic [1:0] REG_RIGHT_DZ  = 2'd1;
   localparam logic [1:0] REG_TRIG_THR  = 2'd2;
   localparam logic [1:0] REG_CHARGE_TH = 2'd3;

   typedef enum logic [3:0] {
      L_IDLE, L_SQX, L_SQY, L_CHK, L_ROOT, L_SCALE, L_NUM, L_DIV, L_OSQX, L_OSQY
   } lane_state_type;

   typedef enum logic [1:0] {
      T_IDLE, T_RUN, T_MERGE
   } top_state_type;

   typedef struct packed {
      logic               idle;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic [30:0]        mag2;
   } lane_result_type;

   typedef struct packed {
      logic [2*NUM_BUTTONS-1:0]  button_states;
      logic signed [15:0]        left_x_out;
      logic signed [15:0]        left_y_out;
      logic signed [15:0]        right_x_out;
      logic signed [15:0]        right_y_out;
      logic [7:0]                left_trigger_out;
      logic [7:0]                right_trigger_out;
      logic [CHARGE_WIDTH-1:0]   left_charge_ticks;
      logic [CHARGE_WIDTH-1:0]   right_charge_ticks;
      logic [1:0]                left_charge_status;
      logic [1:0]                right_charge_status;
   } result_type;

endpackage
`default_nettype wire

// ----- design/gsc_stick_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsc_stick_lane
// One stick: radial deadzone, bit-serial square root, restoring divide per
// axis and the squared magnitude of the conditioned result.
// ----------------------------------------------------------------------------
module gsc_stick_lane (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic signed [15:0]     x_raw,
   input  wire logic signed [15:0]     y_raw,
   input  wire logic [14:0]            deadzone,
   output gsc_pkg::lane_result_type    result
);

   gsc_pkg::lane_state_type state_ff, state_in;
   logic [14:0] ax_ff, ay_ff, dz_ff;
   logic        negx_ff, negy_ff;
   logic [31:0] m2_ff, rem_ff, root_ff, bit_ff;
   logic [4:0]  cnt_ff;
   logic [29:0] num_ff;
   logic [30:0] dv_ff;
   logic [47:0] nx_ff, ny_ff, ds_ff;
   logic [16:0] qx_ff, qy_ff;
   logic [30:0] mag2_ff;

   logic [14:0] ax_c, ay_c;
   logic [29:0] sq_x, sq_y, dz_sq;
   logic [31:0] root_sum;
   logic [15:0] mag;
   logic [14:0] mc, den;
   logic [29:0] num_c;
   logic [30:0] dv_c;
   logic [44:0] px, py;
   logic [14:0] cx, cy;
   logic [29:0] osq_x, osq_y;

   assign ax_c = (x_raw == 16'sh8000) ? 15'd32767 : (x_raw[15] ? 15'(-x_raw) : x_raw[14:0]);
   assign ay_c = (y_raw == 16'sh8000) ? 15'd32767 : (y_raw[15] ? 15'(-y_raw) : y_raw[14:0]);
   assign sq_x  = ax_ff * ax_ff;
   assign sq_y  = ay_ff * ay_ff;
   assign dz_sq = dz_ff * dz_ff;
   assign root_sum = root_ff + bit_ff;
   assign mag = root_ff[15:0];
   assign mc  = (mag > 16'(gsc_pkg::FULL_SCALE)) ? 15'(gsc_pkg::FULL_SCALE) : mag[14:0];
   assign den = 15'(gsc_pkg::FULL_SCALE) - dz_ff;
   assign num_c = (mc - dz_ff) * 15'(gsc_pkg::FULL_SCALE);
   assign dv_c  = mag * den;
   assign px = ax_ff * num_ff;
   assign py = ay_ff * num_ff;
   assign cx = (qx_ff > 17'(gsc_pkg::FULL_SCALE)) ? 15'(gsc_pkg::FULL_SCALE) : qx_ff[14:0];
   assign cy = (qy_ff > 17'(gsc_pkg::FULL_SCALE)) ? 15'(gsc_pkg::FULL_SCALE) : qy_ff[14:0];
   assign osq_x = cx * cx;
   assign osq_y = qy_ff[14:0] * qy_ff[14:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gsc_pkg::L_IDLE:  if (start) state_in = gsc_pkg::L_SQX;
         gsc_pkg::L_SQX:   state_in = gsc_pkg::L_SQY;
         gsc_pkg::L_SQY:   state_in = gsc_pkg::L_CHK;
         gsc_pkg::L_CHK: begin
            if (dz_ff == 15'(gsc_pkg::FULL_SCALE) || m2_ff < 32'(dz_sq)) begin
               state_in = gsc_pkg::L_OSQX;
            end else begin
               state_in = gsc_pkg::L_ROOT;
            end
         end
         gsc_pkg::L_ROOT:  if (cnt_ff == 5'd0) state_in = gsc_pkg::L_SCALE;
         gsc_pkg::L_SCALE: state_in = (mag == 16'd0) ? gsc_pkg::L_OSQX : gsc_pkg::L_NUM;
         gsc_pkg::L_NUM:   state_in = gsc_pkg::L_DIV;
         gsc_pkg::L_DIV:   if (cnt_ff == 5'd0) state_in = gsc_pkg::L_OSQX;
         gsc_pkg::L_OSQX:  state_in = gsc_pkg::L_OSQY;
         gsc_pkg::L_OSQY:  state_in = gsc_pkg::L_IDLE;
         default:          state_in = gsc_pkg::L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsc_pkg::L_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         gsc_pkg::L_IDLE: begin
            if (start) begin
               ax_ff   <= ax_c;
               ay_ff   <= ay_c;
               negx_ff <= x_raw[15];
               negy_ff <= y_raw[15];
               dz_ff   <= deadzone;
            end
         end
         gsc_pkg::L_SQX: m2_ff <= 32'(sq_x);
         gsc_pkg::L_SQY: m2_ff <= m2_ff + 32'(sq_y);
         gsc_pkg::L_CHK: begin
            rem_ff  <= m2_ff;
            root_ff <= 32'd0;
            bit_ff  <= 32'h4000_0000;
            cnt_ff  <= 5'd15;
            qx_ff   <= 17'd0;
            qy_ff   <= 17'd0;
         end
         gsc_pkg::L_ROOT: begin
            if (rem_ff >= root_sum) begin
               rem_ff  <= rem_ff - root_sum;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff - 5'd1;
         end
         gsc_pkg::L_SCALE: begin
            num_ff <= num_c;
            dv_ff  <= dv_c;
         end
         gsc_pkg::L_NUM: begin
            nx_ff  <= {2'b0, px, 1'b0} + 48'(dv_ff);
            ny_ff  <= {2'b0, py, 1'b0} + 48'(dv_ff);
            ds_ff  <= {dv_ff, 17'd0};
            cnt_ff <= 5'd16;
         end
         gsc_pkg::L_DIV: begin
            if (nx_ff >= ds_ff) begin
               nx_ff <= nx_ff - ds_ff;
               qx_ff <= {qx_ff[15:0], 1'b1};
            end else begin
               qx_ff <= {qx_ff[15:0], 1'b0};
            end
            if (ny_ff >= ds_ff) begin
               ny_ff <= ny_ff - ds_ff;
               qy_ff <= {qy_ff[15:0], 1'b1};
            end else begin
               qy_ff <= {qy_ff[15:0], 1'b0};
            end
            ds_ff  <= ds_ff >> 1;
            cnt_ff <= cnt_ff - 5'd1;
         end
         gsc_pkg::L_OSQX: begin
            qx_ff   <= {2'b0, cx};
            qy_ff   <= {2'b0, cy};
            mag2_ff <= 31'(osq_x);
         end
         gsc_pkg::L_OSQY: mag2_ff <= mag2_ff + 31'(osq_y);
         default: ;
      endcase
   end

   assign result.idle  = (state_ff == gsc_pkg::L_IDLE);
   assign result.out_x = negx_ff ? -$signed({1'b0, qx_ff[14:0]}) : $signed({1'b0, qx_ff[14:0]});
   assign result.out_y = negy_ff ? -$signed({1'b0, qy_ff[14:0]}) : $signed({1'b0, qy_ff[14:0]});
   assign result.mag2  = mag2_ff;

endmodule
`default_nettype wire

// ----- design/gsc_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsc_merge
// Combine both lanes with button edges, trigger gating and charge timers.
// ----------------------------------------------------------------------------
module gsc_merge (
   input  wire logic                                connected,
   input  wire logic [gsc_pkg::NUM_BUTTONS-1:0]     button_bits,
   input  wire logic [7:0]                          left_trigger_raw,
   input  wire logic [7:0]                          right_trigger_raw,
   input  wire logic [15:0]                         frame_ticks,
   input  wire logic [7:0]                          trigger_threshold,
   input  wire logic [29:0]                         charge_thr_sq,
   input  wire logic [2*gsc_pkg::NUM_BUTTONS-1:0]   prev_buttons,
   input  wire logic [gsc_pkg::CHARGE_WIDTH-1:0]    prev_time [2],
   input  wire logic                                prev_flag [2],
   input  wire gsc_pkg::lane_result_type            lane [2],
   output gsc_pkg::result_type                      result,
   output logic [2*gsc_pkg::NUM_BUTTONS-1:0]        next_buttons,
   output logic [gsc_pkg::CHARGE_WIDTH-1:0]         next_time [2],
   output logic                                     next_flag [2]
);

   localparam logic [gsc_pkg::CHARGE_WIDTH:0] LIMIT = {1'b0, {gsc_pkg::CHARGE_WIDTH{1'b1}}};

   logic [1:0] status [2];
   logic [gsc_pkg::CHARGE_WIDTH:0] sum [2];

   always_comb begin
      for (int i = 0; i < gsc_pkg::NUM_BUTTONS; i++) begin
         logic was;
         was = (prev_buttons[2*i +: 2] == gsc_pkg::BTN_DOWN) ||
               (prev_buttons[2*i +: 2] == gsc_pkg::BTN_HELD);
         if (button_bits[i]) begin
            next_buttons[2*i +: 2] = was ? gsc_pkg::BTN_HELD : gsc_pkg::BTN_DOWN;
         end else begin
            next_buttons[2*i +: 2] = was ? gsc_pkg::BTN_RELEASED : gsc_pkg::BTN_NONE;
         end
      end
   end

   always_comb begin
      for (int s = 0; s < 2; s++) begin
         sum[s] = {1'b0, prev_time[s]} + (gsc_pkg::CHARGE_WIDTH + 1)'(frame_ticks);
         if (lane[s].mag2 > 31'(charge_thr_sq)) begin
            next_time[s] = (sum[s] > LIMIT) ? LIMIT[gsc_pkg::CHARGE_WIDTH-1:0]
                                            : sum[s][gsc_pkg::CHARGE_WIDTH-1:0];
            next_flag[s] = 1'b1;
            status[s]    = gsc_pkg::CHG_CHARGING;
         end else if (prev_flag[s]) begin
            next_time[s] = prev_time[s];
            next_flag[s] = 1'b0;
            status[s]    = gsc_pkg::CHG_RELEASED;
         end else begin
            next_time[s] = '0;
            next_flag[s] = 1'b0;
            status[s]    = gsc_pkg::CHG_IDLE;
         end
      end
   end

   always_comb begin
      result = '0;
      if (connected) begin
         result.button_states       = next_buttons;
         result.left_x_out          = lane[0].out_x;
         result.left_y_out          = lane[0].out_y;
         result.right_x_out         = lane[1].out_x;
         result.right_y_out         = lane[1].out_y;
         result.left_trigger_out    = (left_trigger_raw < trigger_threshold) ? 8'd0
                                                                             : left_trigger_raw;
         result.right_trigger_out   = (right_trigger_raw < trigger_threshold) ? 8'd0
                                                                              : right_trigger_raw;
         result.left_charge_ticks   = next_time[0];
         result.right_charge_ticks  = next_time[1];
         result.left_charge_status  = status[0];
         result.right_charge_status = status[1];
      end else begin
         result.button_states      = prev_buttons;
         result.left_charge_ticks  = prev_time[0];
         result.right_charge_ticks = prev_time[1];
      end
   end

endmodule
`default_nettype wire

// ----- design/gamepad_stick_conditioner_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_stick_conditioner_top
// Pad frame conditioner: two stick lanes side by side, then a merge stage.
// A connected frame runs both lanes through square root (16 steps) and divide
// (17 steps); a stick inside its deadzone skips both, and a disconnected frame
// goes straight to the merge stage.
// One frame in flight at a time; the next is taken once its result is loaded.
// Reset: synchronous; registers take their reset values, stores clear to zero.
// ----------------------------------------------------------------------------
module gamepad_stick_conditioner_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // button_bits, left_x_raw, left_y_raw, right_x_raw, right_y_raw,
   // left_trigger_raw, right_trigger_raw, frame_ticks
   input  wire logic [111:0]  req_tdata,
   // pad_index, pad_connected
   input  wire logic [2:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // button_states, left_x_out, left_y_out, right_x_out, right_y_out,
   // left_trigger_out, right_trigger_out, left_charge_ticks, right_charge_ticks,
   // left_charge_status, right_charge_status
   output logic [159:0]       rsp_tdata,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [14:0]   csr_data
);

   localparam int BW = 2 * gsc_pkg::NUM_BUTTONS;
   localparam int CW = gsc_pkg::CHARGE_WIDTH;

   gsc_pkg::top_state_type state_ff, state_in;

   logic [14:0] left_dz_ff, right_dz_ff, charge_thr_ff;
   logic [7:0]  trig_thr_ff;
   logic [29:0] thr_sq_ff;

   logic [BW-1:0] button_store_ff [gsc_pkg::PAD_SLOTS];
   logic [CW-1:0] time_store_ff   [2*gsc_pkg::PAD_SLOTS];
   logic          flag_store_ff   [2*gsc_pkg::PAD_SLOTS];

   logic [111:0] data_ff;
   logic [gsc_pkg::PAD_BITS-1:0] pad_ff;
   logic         conn_ff;
   logic         rsp_valid_ff;
   logic [159:0] rsp_data_ff;

   logic accept, start, load;
   gsc_pkg::lane_result_type lane [2];
   gsc_pkg::result_type      result;
   logic [BW-1:0] next_buttons;
   logic [CW-1:0] prev_time [2], next_time [2];
   logic          prev_flag [2], next_flag [2];

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == gsc_pkg::T_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && req_tuser[2];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_dz_ff    <= 15'd7864;
         right_dz_ff   <= 15'd8689;
         trig_thr_ff   <= 8'd30;
         charge_thr_ff <= 15'd16384;
      end else if (csr_valid) begin
         unique case (csr_index)
            gsc_pkg::REG_LEFT_DZ:   left_dz_ff    <= csr_data;
            gsc_pkg::REG_RIGHT_DZ:  right_dz_ff   <= csr_data;
            gsc_pkg::REG_TRIG_THR:  trig_thr_ff   <= csr_data[7:0];
            gsc_pkg::REG_CHARGE_TH: charge_thr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      thr_sq_ff <= charge_thr_ff * charge_thr_ff;
   end

   gsc_stick_lane u_left (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .x_raw    ($signed(req_tdata[29:14])),
      .y_raw    ($signed(req_tdata[45:30])),
      .deadzone (left_dz_ff),
      .result   (lane[0])
   );

   gsc_stick_lane u_right (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .x_raw    ($signed(req_tdata[61:46])),
      .y_raw    ($signed(req_tdata[77:62])),
      .deadzone (right_dz_ff),
      .result   (lane[1])
   );

   assign prev_time[0] = time_store_ff[{pad_ff, 1'b0}];
   assign prev_time[1] = time_store_ff[{pad_ff, 1'b1}];
   assign prev_flag[0] = flag_store_ff[{pad_ff, 1'b0}];
   assign prev_flag[1] = flag_store_ff[{pad_ff, 1'b1}];

   gsc_merge u_merge (
      .connected         (conn_ff),
      .button_bits       (data_ff[13:0]),
      .left_trigger_raw  (data_ff[85:78]),
      .right_trigger_raw (data_ff[93:86]),
      .frame_ticks       (data_ff[109:94]),
      .trigger_threshold (trig_thr_ff),
      .charge_thr_sq     (thr_sq_ff),
      .prev_buttons      (button_store_ff[pad_ff]),
      .prev_time         (prev_time),
      .prev_flag         (prev_flag),
      .lane              (lane),
      .result            (result),
      .next_buttons      (next_buttons),
      .next_time         (next_time),
      .next_flag         (next_flag)
   );

   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      unique case (state_ff)
         gsc_pkg::T_IDLE: begin
            if (accept) state_in = req_tuser[2] ? gsc_pkg::T_RUN : gsc_pkg::T_MERGE;
         end
         gsc_pkg::T_RUN: begin
            if (lane[0].idle && lane[1].idle) state_in = gsc_pkg::T_MERGE;
         end
         gsc_pkg::T_MERGE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load     = 1'b1;
               state_in = gsc_pkg::T_IDLE;
            end
         end
         default: state_in = gsc_pkg::T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsc_pkg::T_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < gsc_pkg::PAD_SLOTS; p++) button_store_ff[p] <= '0;
         for (int s = 0; s < 2*gsc_pkg::PAD_SLOTS; s++) begin
            time_store_ff[s] <= '0;
            flag_store_ff[s] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load && conn_ff) begin
            button_store_ff[pad_ff]          <= next_buttons;
            time_store_ff[{pad_ff, 1'b0}]    <= next_time[0];
            time_store_ff[{pad_ff, 1'b1}]    <= next_time[1];
            flag_store_ff[{pad_ff, 1'b0}]    <= next_flag[0];
            flag_store_ff[{pad_ff, 1'b1}]    <= next_flag[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_tdata;
         pad_ff  <= req_tuser[1:0];
         conn_ff <= req_tuser[2];
      end
      if (load) rsp_data_ff <= {
         result.right_charge_status, result.left_charge_status,
         result.right_charge_ticks, result.left_charge_ticks,
         result.right_trigger_out, result.left_trigger_out,
         result.right_y_out, result.right_x_out,
         result.left_y_out, result.left_x_out,
         result.button_states};
   end

endmodule
`default_nettype wire

// ----- design/gsc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsc_checker
// Port-level checks of the conditioner, bound to the top level.
// ----------------------------------------------------------------------------
module gsc_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [159:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word right after reset");

   a_one_frame: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second frame taken while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[157:156] != 2'd3 && rsp_tdata[159:158] != 2'd3)
      else $error("bad charge status");

endmodule

bind gamepad_stick_conditioner_top gsc_checker u_gsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the gamepad stick conditioner: drives pad frames
// and register writes, predicts every result word in a scoreboard and checks
// each one field by field, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic [27:0]        buttons;
      logic signed [15:0] lx, ly, rx, ry;
      logic [7:0]         lt, rt;
      logic [23:0]        lticks, rticks;
      logic [1:0]         lstat, rstat;
   } frame_result_type;

   typedef struct {
      logic [1:0]         pad;
      logic               conn;
      logic [13:0]        btn;
      logic signed [15:0] lx, ly, rx, ry;
      logic [7:0]         lt, rt;
      logic [15:0]        ticks;
   } frame_type;

   class pad_scoreboard_type;
      logic [14:0] left_dz, right_dz, charge_thr;
      logic [7:0]  trig_thr;
      logic [27:0] btn_store [gsc_pkg::PAD_SLOTS];
      logic [23:0] charge_store [2*gsc_pkg::PAD_SLOTS];
      bit          charging_flag [2*gsc_pkg::PAD_SLOTS];
      frame_result_type pending [$];
      int errors;
      int checked;

      function new();
         left_dz = 7864; right_dz = 8689; trig_thr = 30; charge_thr = 16384;
         foreach (btn_store[i]) btn_store[i] = 0;
         foreach (charge_store[i]) begin
            charge_store[i] = 0; charging_flag[i] = 0;
         end
         errors = 0; checked = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [14:0] v);
         case (idx)
            gsc_pkg::REG_LEFT_DZ:   left_dz = v;
            gsc_pkg::REG_RIGHT_DZ:  right_dz = v;
            gsc_pkg::REG_TRIG_THR:  trig_thr = v[7:0];
            gsc_pkg::REG_CHARGE_TH: charge_thr = v;
         endcase
      endfunction

      function longint unsigned root_floor(longint unsigned n);
         longint unsigned r, b;
         r = 0; b = 64'd1 << 32;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n -= r + b; r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
         end
         return r;
      endfunction

      function void shape_stick(logic signed [15:0] xr, logic signed [15:0] yr,
                                logic [14:0] dz, output logic signed [15:0] ox,
                                output logic signed [15:0] oy);
         longint x, y, ax, ay, m2, mag, mc, num, dv, qx, qy;
         x = (xr == -16'sd32768) ? -32767 : xr;
         y = (yr == -16'sd32768) ? -32767 : yr;
         ax = x < 0 ? -x : x; ay = y < 0 ? -y : y;
         m2 = ax*ax + ay*ay;
         ox = 0; oy = 0;
         if (dz >= gsc_pkg::FULL_SCALE || m2 < longint'(dz)*dz) return;
         mag = root_floor(m2);
         if (mag == 0) return;
         mc = mag > gsc_pkg::FULL_SCALE ? gsc_pkg::FULL_SCALE : mag;
         num = (mc - dz) * gsc_pkg::FULL_SCALE;
         dv = mag * (gsc_pkg::FULL_SCALE - dz);
         qx = (2*ax*num + dv) / (2*dv);
         qy = (2*ay*num + dv) / (2*dv);
         if (qx > gsc_pkg::FULL_SCALE) qx = gsc_pkg::FULL_SCALE;
         if (qy > gsc_pkg::FULL_SCALE) qy = gsc_pkg::FULL_SCALE;
         ox = x < 0 ? -qx : qx; oy = y < 0 ? -qy : qy;
      endfunction

      function logic [23:0] update_charge(int s, logic signed [15:0] ox,
                                          logic signed [15:0] oy, logic [15:0] t,
                                          output logic [1:0] st);
         longint m2, sum;
         m2 = longint'(ox)*ox + longint'(oy)*oy;
         if (m2 > longint'(charge_thr)*charge_thr) begin
            sum = longint'(charge_store[s]) + t;
            charge_store[s] = sum > 24'hFFFFFF ? 24'hFFFFFF : sum;
            charging_flag[s] = 1; st = gsc_pkg::CHG_CHARGING;
         end else begin
            if (charging_flag[s]) st = gsc_pkg::CHG_RELEASED;
            else begin
               charge_store[s] = 0; st = gsc_pkg::CHG_IDLE;
            end
            charging_flag[s] = 0;
         end
         return charge_store[s];
      endfunction

      function void note_frame(frame_type f);
         frame_result_type e;
         logic [1:0] s;
         bit was;
         e = '{default: 0};
         if (!f.conn) begin
            e.buttons = btn_store[f.pad];
            e.lticks = charge_store[2*f.pad];
            e.rticks = charge_store[2*f.pad+1];
         end else begin
            for (int i = 0; i < gsc_pkg::NUM_BUTTONS; i++) begin
               s = btn_store[f.pad][2*i +: 2];
               was = (s == gsc_pkg::BTN_DOWN || s == gsc_pkg::BTN_HELD);
               e.buttons[2*i +: 2] = f.btn[i]
                  ? (was ? gsc_pkg::BTN_HELD : gsc_pkg::BTN_DOWN)
                  : (was ? gsc_pkg::BTN_RELEASED : gsc_pkg::BTN_NONE);
            end
            btn_store[f.pad] = e.buttons;
            shape_stick(f.lx, f.ly, left_dz, e.lx, e.ly);
            shape_stick(f.rx, f.ry, right_dz, e.rx, e.ry);
            e.lt = f.lt < trig_thr ? 0 : f.lt;
            e.rt = f.rt < trig_thr ? 0 : f.rt;
            e.lticks = update_charge(2*f.pad, e.lx, e.ly, f.ticks, e.lstat);
            e.rticks = update_charge(2*f.pad+1, e.rx, e.ry, f.ticks, e.rstat);
         end
         pending.push_back(e);
      endfunction

      function void compare(string n, longint exp_v, longint act_v);
         if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", n, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_word(logic [159:0] d);
         frame_result_type e;
         checked++;
         if (pending.size() == 0) begin
            $error("result word with no frame outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         compare("button_states", e.buttons, d[27:0]);
         compare("left_x_out", e.lx, $signed(d[43:28]));
         compare("left_y_out", e.ly, $signed(d[59:44]));
         compare("right_x_out", e.rx, $signed(d[75:60]));
         compare("right_y_out", e.ry, $signed(d[91:76]));
         compare("left_trigger_out", e.lt, d[99:92]);
         compare("right_trigger_out", e.rt, d[107:100]);
         compare("left_charge_ticks", e.lticks, d[131:108]);
         compare("right_charge_ticks", e.rticks, d[155:132]);
         compare("left_charge_status", e.lstat, d[157:156]);
         compare("right_charge_status", e.rstat, d[159:158]);
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0, csr_valid = 0;
   logic [111:0] req_tdata = 0;
   logic [2:0] req_tuser = 0;
   logic [1:0] csr_index = 0;
   logic [14:0] csr_data = 0;
   wire req_tready, rsp_tvalid, csr_ready;
   wire [159:0] rsp_tdata;

   pad_scoreboard_type sb = new();
   int cycles = 0;
   bit hold_rsp = 0;
   int sent = 0;

   gamepad_stick_conditioner_top dut (.*);

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   // receiver: random stalls, plus a long hold when asked
   initial begin
      int g;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         g = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [14:0] v);
      csr_index <= idx; csr_data <= v; csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.write_reg(idx, v);
   endtask

   task automatic send_frame(frame_type f, bit gaps);
      int g;
      g = gaps ? pick_gap() : 0;
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tuser <= {f.conn, f.pad};
      req_tdata <= {2'b00, f.ticks, f.rt, f.lt, f.ry, f.rx, f.ly, f.lx, f.btn};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sb.note_frame(f);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function logic signed [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return $urandom_range(0, 3000) - 1500;
         default: return $urandom();
      endcase
   endfunction

   function frame_type rand_frame();
      frame_type f;
      f.pad = $urandom(); f.conn = ($urandom_range(0, 7) != 0);
      f.btn = ($urandom_range(0, 2) == 0) ? 14'h0 : $urandom();
      f.lx = rand_axis(); f.ly = rand_axis(); f.rx = rand_axis(); f.ry = rand_axis();
      f.lt = $urandom(); f.rt = $urandom();
      f.ticks = ($urandom_range(0, 9) == 0) ? 16'hFFFF : $urandom();
      return f;
   endfunction

   initial begin
      frame_type f;
      logic signed [15:0] ax [6];
      ax = '{16'sh8000, 16'sh7FFF, 0, 1, -1, 16'sh4000};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes with reset settings
      for (int i = 0; i < 12; i++) begin
         f = rand_frame();
         f.pad = i % 4; f.conn = (i != 5);
         f.btn = (i % 2) ? 14'h3FFF : 14'h0;
         f.lx = ax[i % 6]; f.ly = ax[(i + 1) % 6];
         f.rx = ax[(i + 2) % 6]; f.ry = ax[(i + 3) % 6];
         f.lt = (i % 3 == 0) ? 8'd29 : (i % 3 == 1) ? 8'd30 : 8'hFF;
         f.rt = ~f.lt; f.ticks = 16'hFFFF;
         send_frame(f, 0);
      end
      drain();
      // zero deadzone with a centered stick, full-scale deadzone on the right
      write_csr(gsc_pkg::REG_LEFT_DZ, 0);
      write_csr(gsc_pkg::REG_RIGHT_DZ, 15'd32767);
      write_csr(gsc_pkg::REG_TRIG_THR, 0);
      write_csr(gsc_pkg::REG_CHARGE_TH, 0);
      for (int i = 0; i < 6; i++) begin
         f = rand_frame(); f.conn = 1;
         f.lx = (i < 3) ? 0 : ax[i]; f.ly = 0;
         send_frame(f, 1);
      end
      drain();
      write_csr(gsc_pkg::REG_RIGHT_DZ, 15'd32766);
      write_csr(gsc_pkg::REG_TRIG_THR, 8'hFF);
      write_csr(gsc_pkg::REG_CHARGE_TH, 15'd32767);
      for (int i = 0; i < 6; i++) send_frame(rand_frame(), 1);
      drain();

      // random phases under varied settings; long charge runs keep ticks climbing
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(gsc_pkg::REG_LEFT_DZ, $urandom_range(0, 12000));
         write_csr(gsc_pkg::REG_RIGHT_DZ, $urandom_range(0, 12000));
         write_csr(gsc_pkg::REG_TRIG_THR, $urandom_range(0, 255));
         write_csr(gsc_pkg::REG_CHARGE_TH, $urandom_range(0, 30000));
         if (ph == 2) hold_rsp = 1;
         for (int i = 0; i < 120; i++) begin
            f = rand_frame();
            if ($urandom_range(0, 1)) begin
               f.lx = 16'sh7FFF; f.rx = 16'sh8000; f.conn = 1;
               f.ticks = 16'hFFFF;
            end
            send_frame(f, ph != 3);
         end
         drain();
      end
      write_csr(gsc_pkg::REG_LEFT_DZ, 7864);
      write_csr(gsc_pkg::REG_RIGHT_DZ, 8689);
      write_csr(gsc_pkg::REG_TRIG_THR, 30);
      write_csr(gsc_pkg::REG_CHARGE_TH, 16384);
      for (int i = 0; i < 20; i++) send_frame(rand_frame(), 1);
      drain();

      $display("Sent %0d frames across %0d cycles; %0d result words checked.",
               sent, cycles, sb.checked);
      $display("Register extremes, disconnected frames and long charge runs covered.");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
